>>> hdl/dha_pkg.sv
package dha_pkg;

    localparam int COORD_BITS      = 32;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 20;

    localparam int VW = COORD_BITS + 1;
    localparam int PW = 2 * VW;
    localparam int NW = PW + 1;
    localparam int TW = VW + NW + 2;
    localparam int XW = 2 * NW + 2;
    localparam int LW = PW + 2;

    localparam int SQRT_SHIFT = 32;
    localparam int RW  = (LW + 2 * SQRT_SHIFT + 1) / 2;
    localparam int SW  = 2 * RW;
    localparam int RMW = RW + 3;

    localparam int YW = RW + TW;
    localparam int SHW = $clog2(YW);
    localparam int NORM_BITS = 30;
    localparam int CXW = NORM_BITS + 4;

    localparam int NLO = NW / 2;
    localparam int NHI = NW - NLO;
    localparam int RLO = RW / 2;
    localparam int RHI = RW - RLO;
    localparam int T0W = TW / 3;
    localparam int T2W = TW - 2 * T0W;
    localparam int MPW = RHI + T2W + 2;

    localparam int ZF  = 61;
    localparam int ZW  = 64;
    localparam int AW  = ANGLE_FRAC_BITS + 3;
    localparam int RND = ZF - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] PI_Z       = 64'sh6487ED5110B4611A;
    localparam logic signed [ZW-1:0] QPI_Z      = 64'sh1921FB54442D1846;
    localparam logic signed [ZW-1:0] HPI_Z      = 64'sh3243F6A8885A308C;
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1) <<< (RND - 1);
    localparam logic signed [ZW-1:0] LIM_Z      = (PI_Z + ROUND_HALF) >>> RND;
    localparam logic signed [AW-1:0] ANGLE_LIM  = AW'(LIM_Z);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
    } nrm_t;

    typedef struct packed {
        vec_t v1;
        vec_t v2;
        nrm_t n1;
        nrm_t n2;
    } geom_t;

    typedef logic signed [ZW-1:0] ztab_t [CORDIC_STEPS];

    function automatic longint quotient(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den)
            begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    function automatic ztab_t atan_table();
        ztab_t  tab;
        longint acc;
        longint term;
        int     e;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (i == 0)
            begin
                tab[i] = QPI_Z;
            end
            else
            begin
                acc = 0;
                for (int n = 0; n < 32; n++)
                begin
                    e = ZF - i * (2 * n + 1);
                    if (e >= 0)
                    begin
                        term = quotient(longint'(1) <<< e, longint'(2 * n + 1));
                        acc = ((n & 1) == 1) ? acc - term : acc + term;
                    end
                end
                tab[i] = acc;
            end
        end
        return tab;
    endfunction

    localparam ztab_t ATAN_TAB = atan_table();

endpackage

>>> hdl/dha_front.sv
module dha_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_z,
    output logic                                 push,
    output dha_pkg::geom_t                       push_data
);
    import dha_pkg::*;

    vec_t              v1_reg, v2_reg, v3_reg;
    logic              s1_valid_reg;
    vec_t              v1_s2_reg, v2_s2_reg;
    logic signed [PW-1:0] pa_reg [6];
    logic signed [PW-1:0] pb_reg [6];
    logic              s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg.x <= VW'(p2_x) - VW'(p1_x);
        v1_reg.y <= VW'(p2_y) - VW'(p1_y);
        v1_reg.z <= VW'(p2_z) - VW'(p1_z);
        v2_reg.x <= VW'(p3_x) - VW'(p2_x);
        v2_reg.y <= VW'(p3_y) - VW'(p2_y);
        v2_reg.z <= VW'(p3_z) - VW'(p2_z);
        v3_reg.x <= VW'(p4_x) - VW'(p3_x);
        v3_reg.y <= VW'(p4_y) - VW'(p3_y);
        v3_reg.z <= VW'(p4_z) - VW'(p3_z);
    end

    always_ff @(posedge clk)
    begin
        v1_s2_reg <= v1_reg;
        v2_s2_reg <= v2_reg;
        pa_reg[0] <= $signed(v1_reg.y) * $signed(v2_reg.z);
        pb_reg[0] <= $signed(v1_reg.z) * $signed(v2_reg.y);
        pa_reg[1] <= $signed(v1_reg.z) * $signed(v2_reg.x);
        pb_reg[1] <= $signed(v1_reg.x) * $signed(v2_reg.z);
        pa_reg[2] <= $signed(v1_reg.x) * $signed(v2_reg.y);
        pb_reg[2] <= $signed(v1_reg.y) * $signed(v2_reg.x);
        pa_reg[3] <= $signed(v2_reg.y) * $signed(v3_reg.z);
        pb_reg[3] <= $signed(v2_reg.z) * $signed(v3_reg.y);
        pa_reg[4] <= $signed(v2_reg.z) * $signed(v3_reg.x);
        pb_reg[4] <= $signed(v2_reg.x) * $signed(v3_reg.z);
        pa_reg[5] <= $signed(v2_reg.x) * $signed(v3_reg.y);
        pb_reg[5] <= $signed(v2_reg.y) * $signed(v3_reg.x);
    end

    always_comb
    begin
        push_data.v1   = v1_s2_reg;
        push_data.v2   = v2_s2_reg;
        push_data.n1.x = NW'(pa_reg[0]) - NW'(pb_reg[0]);
        push_data.n1.y = NW'(pa_reg[1]) - NW'(pb_reg[1]);
        push_data.n1.z = NW'(pa_reg[2]) - NW'(pb_reg[2]);
        push_data.n2.x = NW'(pa_reg[3]) - NW'(pb_reg[3]);
        push_data.n2.y = NW'(pa_reg[4]) - NW'(pb_reg[4]);
        push_data.n2.z = NW'(pa_reg[5]) - NW'(pb_reg[5]);
    end

    assign push = s2_valid_reg;

endmodule

>>> hdl/dha_queue.sv
module dha_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dha_pkg::geom_t push_data,
    input  logic           pop,
    output logic           head_valid,
    output dha_pkg::geom_t head_data,
    output logic           full
);
    import dha_pkg::*;

    geom_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push, do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QAW + 1)'(QDEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/dha_sqrt.sv
module dha_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [dha_pkg::LW-1:0]       in_l,
    input  logic signed [dha_pkg::TW-1:0] in_t,
    input  logic signed [dha_pkg::XW-1:0] in_x,
    output logic                         out_valid,
    output logic [dha_pkg::RW-1:0]       out_r,
    output logic signed [dha_pkg::TW-1:0] out_t,
    output logic signed [dha_pkg::XW-1:0] out_x
);
    import dha_pkg::*;

    logic [RMW-1:0]       rem_reg   [RW];
    logic [RW-1:0]        root_reg  [RW];
    logic [LW-1:0]        l_reg     [RW];
    logic signed [TW-1:0] t_reg     [RW];
    logic signed [XW-1:0] x_reg     [RW];
    logic                 valid_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int J = RW - 1 - k;
        logic [RMW-1:0]       rem_prev, rem_sh, trial;
        logic [RW-1:0]        root_prev;
        logic [LW-1:0]        l_prev;
        logic signed [TW-1:0] t_prev;
        logic signed [XW-1:0] x_prev;
        logic                 v_prev;
        logic [SW-1:0]        opnd;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign l_prev    = in_l;
            assign t_prev    = in_t;
            assign x_prev    = in_x;
            assign v_prev    = in_valid;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign l_prev    = l_reg[k-1];
            assign t_prev    = t_reg[k-1];
            assign x_prev    = x_reg[k-1];
            assign v_prev    = valid_reg[k-1];
        end

        assign opnd   = SW'(l_prev) << (2 * SQRT_SHIFT);
        assign rem_sh = {rem_prev[RMW-3:0], opnd[2*J +: 2]};
        assign trial  = (RMW'(root_prev) << 2) | RMW'(1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_sh >= trial)
            begin
                rem_reg[k]  <= rem_sh - trial;
                root_reg[k] <= {root_prev[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= rem_sh;
                root_reg[k] <= {root_prev[RW-2:0], 1'b0};
            end
            l_reg[k] <= l_prev;
            t_reg[k] <= t_prev;
            x_reg[k] <= x_prev;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_r     = root_reg[RW-1];
    assign out_t     = t_reg[RW-1];
    assign out_x     = x_reg[RW-1];

endmodule

>>> hdl/dha_cordic.sv
module dha_cordic (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [dha_pkg::YW-1:0] in_y,
    input  logic signed [dha_pkg::YW-1:0] in_x,
    output logic                         done,
    output logic signed [dha_pkg::AW-1:0] angle,
    output logic                         degenerate
);
    import dha_pkg::*;

    logic [YW-1:0] ym0_reg, xm0_reg;
    logic          yn0_reg, xn0_reg, zero0_reg, valid0_reg;

    logic [YW-1:0] ym_reg    [SHW];
    logic [YW-1:0] xm_reg    [SHW];
    logic          yn_reg    [SHW];
    logic          xn_reg    [SHW];
    logic          zero_reg  [SHW];
    logic          nvalid_reg [SHW];

    logic signed [CXW-1:0] cx_reg    [CORDIC_STEPS+1];
    logic signed [CXW-1:0] cy_reg    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]  cz_reg    [CORDIC_STEPS+1];
    logic                  czero_reg [CORDIC_STEPS+1];
    logic                  cvalid_reg [CORDIC_STEPS+1];

    logic                  done_reg, degenerate_reg;
    logic signed [AW-1:0]  angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        yn0_reg   <= in_y[YW-1];
        xn0_reg   <= in_x[YW-1];
        ym0_reg   <= in_y[YW-1] ? YW'(-in_y) : YW'(in_y);
        xm0_reg   <= in_x[YW-1] ? YW'(-in_x) : YW'(in_x);
        zero0_reg <= (in_y == '0) && (in_x == '0);
    end

    for (genvar s = 0; s < SHW; s++)
    begin : g_norm
        localparam int S = 1 << (SHW - 1 - s);
        logic [YW-1:0] ym_prev, xm_prev, orv;
        logic          yn_prev, xn_prev, zero_prev, v_prev;

        if (s == 0)
        begin : g_first
            assign ym_prev   = ym0_reg;
            assign xm_prev   = xm0_reg;
            assign yn_prev   = yn0_reg;
            assign xn_prev   = xn0_reg;
            assign zero_prev = zero0_reg;
            assign v_prev    = valid0_reg;
        end
        else
        begin : g_next
            assign ym_prev   = ym_reg[s-1];
            assign xm_prev   = xm_reg[s-1];
            assign yn_prev   = yn_reg[s-1];
            assign xn_prev   = xn_reg[s-1];
            assign zero_prev = zero_reg[s-1];
            assign v_prev    = nvalid_reg[s-1];
        end

        assign orv = ym_prev | xm_prev;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nvalid_reg[s] <= 1'b0;
            end
            else
            begin
                nvalid_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (orv[YW-1 -: S] == '0)
            begin
                ym_reg[s] <= ym_prev << S;
                xm_reg[s] <= xm_prev << S;
            end
            else
            begin
                ym_reg[s] <= ym_prev;
                xm_reg[s] <= xm_prev;
            end
            yn_reg[s]   <= yn_prev;
            xn_reg[s]   <= xn_prev;
            zero_reg[s] <= zero_prev;
        end
    end

    logic signed [CXW-1:0] ya, xa;

    always_comb
    begin
        ya = $signed(CXW'(ym_reg[SHW-1][YW-1 -: NORM_BITS]));
        xa = $signed(CXW'(xm_reg[SHW-1][YW-1 -: NORM_BITS]));
        if (yn_reg[SHW-1])
        begin
            ya = -ya;
        end
        if (xn_reg[SHW-1])
        begin
            xa = -xa;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg[0] <= 1'b0;
        end
        else
        begin
            cvalid_reg[0] <= nvalid_reg[SHW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        czero_reg[0] <= zero_reg[SHW-1];
        if (xa[CXW-1] && !ya[CXW-1])
        begin
            cx_reg[0] <= ya;
            cy_reg[0] <= -xa;
            cz_reg[0] <= HPI_Z;
        end
        else if (xa[CXW-1])
        begin
            cx_reg[0] <= -ya;
            cy_reg[0] <= xa;
            cz_reg[0] <= -HPI_Z;
        end
        else
        begin
            cx_reg[0] <= xa;
            cy_reg[0] <= ya;
            cz_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CXW-1:0] dx, dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cvalid_reg[i+1] <= 1'b0;
            end
            else
            begin
                cvalid_reg[i+1] <= cvalid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!cy_reg[i][CXW-1])
            begin
                cx_reg[i+1] <= cx_reg[i] + dx;
                cy_reg[i+1] <= cy_reg[i] - dy;
                cz_reg[i+1] <= cz_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - dx;
                cy_reg[i+1] <= cy_reg[i] + dy;
                cz_reg[i+1] <= cz_reg[i] - ATAN_TAB[i];
            end
            czero_reg[i+1] <= czero_reg[i];
        end
    end

    logic signed [ZW-1:0] a_full;
    logic signed [AW-1:0] angle_next;

    always_comb
    begin
        a_full = (cz_reg[CORDIC_STEPS] + ROUND_HALF) >>> RND;
        if (czero_reg[CORDIC_STEPS])
        begin
            angle_next = '0;
        end
        else if (a_full > LIM_Z)
        begin
            angle_next = ANGLE_LIM;
        end
        else if (a_full < -LIM_Z)
        begin
            angle_next = -ANGLE_LIM;
        end
        else
        begin
            angle_next = AW'(a_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cvalid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg      <= angle_next;
        degenerate_reg <= czero_reg[CORDIC_STEPS];
    end

    assign done       = done_reg;
    assign angle      = angle_reg;
    assign degenerate = degenerate_reg;

endmodule

>>> hdl/dha_back.sv
module dha_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  dha_pkg::geom_t               in_data,
    output logic                         done,
    output logic signed [dha_pkg::AW-1:0] angle,
    output logic                         degenerate
);
    import dha_pkg::*;

    localparam int TLW = VW + NLO + 1;
    localparam int THW = VW + NHI;
    localparam int LLW = 2 * NLO + 2;
    localparam int LHW = NLO + 1 + NHI;
    localparam int HHW = 2 * NHI;

    logic signed [VW-1:0] va [3];
    logic signed [VW-1:0] vb [3];
    logic signed [NW-1:0] na [3];
    logic signed [NW-1:0] nb [3];

    assign va[0] = in_data.v1.x;
    assign va[1] = in_data.v1.y;
    assign va[2] = in_data.v1.z;
    assign vb[0] = in_data.v2.x;
    assign vb[1] = in_data.v2.y;
    assign vb[2] = in_data.v2.z;
    assign na[0] = in_data.n1.x;
    assign na[1] = in_data.n1.y;
    assign na[2] = in_data.n1.z;
    assign nb[0] = in_data.n2.x;
    assign nb[1] = in_data.n2.y;
    assign nb[2] = in_data.n2.z;

    logic signed [TLW-1:0] tlo_reg [3];
    logic signed [THW-1:0] thi_reg [3];
    logic signed [LLW-1:0] ll_reg  [3];
    logic signed [LHW-1:0] lh_reg  [3];
    logic signed [LHW-1:0] hl_reg  [3];
    logic signed [HHW-1:0] hh_reg  [3];
    logic signed [PW-1:0]  sq_reg  [3];
    logic                  d1_valid_reg;

    logic signed [TW-1:0]  tp_reg [3];
    logic signed [XW-1:0]  xp_reg [3];
    logic [LW-1:0]         l2_reg;
    logic                  d2_valid_reg;

    logic signed [TW-1:0]  t_reg;
    logic signed [XW-1:0]  x_reg;
    logic [LW-1:0]         l_reg;
    logic                  d3_valid_reg;

    logic                  sq_valid;
    logic [RW-1:0]         sq_r;
    logic signed [TW-1:0]  sq_t;
    logic signed [XW-1:0]  sq_x;

    logic signed [MPW-1:0] mp_reg [2][3];
    logic signed [XW-1:0]  x_m1_reg;
    logic                  m1_valid_reg;

    logic signed [YW-1:0]  ys_reg [2];
    logic signed [XW-1:0]  x_m2_reg;
    logic                  m2_valid_reg;

    logic signed [YW-1:0]  y_reg, xw_reg;
    logic                  m3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            d1_valid_reg <= in_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            m1_valid_reg <= sq_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            tlo_reg[c] <= va[c] * $signed({1'b0, nb[c][NLO-1:0]});
            thi_reg[c] <= va[c] * $signed(nb[c][NW-1:NLO]);
            ll_reg[c]  <= $signed({1'b0, na[c][NLO-1:0]}) * $signed({1'b0, nb[c][NLO-1:0]});
            lh_reg[c]  <= $signed({1'b0, na[c][NLO-1:0]}) * $signed(nb[c][NW-1:NLO]);
            hl_reg[c]  <= $signed(na[c][NW-1:NLO]) * $signed({1'b0, nb[c][NLO-1:0]});
            hh_reg[c]  <= $signed(na[c][NW-1:NLO]) * $signed(nb[c][NW-1:NLO]);
            sq_reg[c]  <= vb[c] * vb[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            tp_reg[c] <= (TW'(thi_reg[c]) <<< NLO) + TW'(tlo_reg[c]);
            xp_reg[c] <= (XW'(hh_reg[c]) <<< (2 * NLO))
                       + ((XW'(lh_reg[c]) + XW'(hl_reg[c])) <<< NLO)
                       + XW'(ll_reg[c]);
        end
        l2_reg <= LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        t_reg <= tp_reg[0] + tp_reg[1] + tp_reg[2];
        x_reg <= xp_reg[0] + xp_reg[1] + xp_reg[2];
        l_reg <= l2_reg;
    end

    dha_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d3_valid_reg),
        .in_l      (l_reg),
        .in_t      (t_reg),
        .in_x      (x_reg),
        .out_valid (sq_valid),
        .out_r     (sq_r),
        .out_t     (sq_t),
        .out_x     (sq_x)
    );

    always_ff @(posedge clk)
    begin
        mp_reg[0][0] <= $signed({1'b0, sq_r[RLO-1:0]}) * $signed({1'b0, sq_t[T0W-1:0]});
        mp_reg[0][1] <= $signed({1'b0, sq_r[RLO-1:0]}) * $signed({1'b0, sq_t[2*T0W-1:T0W]});
        mp_reg[0][2] <= $signed({1'b0, sq_r[RLO-1:0]}) * $signed(sq_t[TW-1:2*T0W]);
        mp_reg[1][0] <= $signed({1'b0, sq_r[RW-1:RLO]}) * $signed({1'b0, sq_t[T0W-1:0]});
        mp_reg[1][1] <= $signed({1'b0, sq_r[RW-1:RLO]}) * $signed({1'b0, sq_t[2*T0W-1:T0W]});
        mp_reg[1][2] <= $signed({1'b0, sq_r[RW-1:RLO]}) * $signed(sq_t[TW-1:2*T0W]);
        x_m1_reg     <= sq_x;
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            ys_reg[a] <= YW'(mp_reg[a][0])
                       + (YW'(mp_reg[a][1]) <<< T0W)
                       + (YW'(mp_reg[a][2]) <<< (2 * T0W));
        end
        x_m2_reg <= x_m1_reg;
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= ys_reg[0] + (ys_reg[1] <<< RLO);
        xw_reg <= YW'(x_m2_reg) <<< SQRT_SHIFT;
    end

    dha_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (m3_valid_reg),
        .in_y       (y_reg),
        .in_x       (xw_reg),
        .done       (done),
        .angle      (angle),
        .degenerate (degenerate)
    );

endmodule

>>> hdl/dihedral_angle_3d.sv
// Throughput: one request per clock cycle while busy is low, fully pipelined; the square
// root takes one stage per root bit and the arctangent one stage per rotation.
// Reset is asynchronous and active low; it empties the queue and the pipeline.
// Results cannot be held off, so busy only rises if the queue between front and back fills.
module dihedral_angle_3d (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p1_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p2_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p3_z,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_x,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_y,
    input  logic signed [dha_pkg::COORD_BITS-1:0] p4_z,
    output logic                                 done,
    output logic signed [dha_pkg::AW-1:0]         angle,
    output logic                                 degenerate
);
    import dha_pkg::*;

    logic  take;
    logic  push;
    geom_t push_data;
    logic  head_valid;
    geom_t head_data;
    logic  full;

    assign take = start && !busy;
    assign busy = full;

    dha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .p1_x      (p1_x),
        .p1_y      (p1_y),
        .p1_z      (p1_z),
        .p2_x      (p2_x),
        .p2_y      (p2_y),
        .p2_z      (p2_z),
        .p3_x      (p3_x),
        .p3_y      (p3_y),
        .p3_z      (p3_z),
        .p4_x      (p4_x),
        .p4_y      (p4_y),
        .p4_z      (p4_z),
        .push      (push),
        .push_data (push_data)
    );

    dha_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (head_valid),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (full)
    );

    dha_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (head_valid),
        .in_data    (head_data),
        .done       (done),
        .angle      (angle),
        .degenerate (degenerate)
    );

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dha_pkg::*;

    localparam int          DRAIN_CYCLES = 120;
    localparam int          STALL_LIMIT  = 3000;
    localparam longint      PI_Q61       = 64'sh6487ED5110B4611A;
    localparam longint      QUARTER_PI   = 64'sh1921FB54442D1846;
    localparam int          Q_FRAC       = 61;
    localparam int          NORM_WIDTH   = 30;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] c [12];
    } quad_t;

    typedef struct {
        logic signed [AW-1:0] angle;
        logic                 degenerate;
    } torsion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start;
    logic busy;
    logic done;
    logic signed [AW-1:0] angle;
    logic degenerate;
    logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic signed [COORD_BITS-1:0] p3_x, p3_y, p3_z, p4_x, p4_y, p4_z;

    torsion_t expected_torsions [$];
    int       errors = 0;
    int       idle_cycles = 0;

    dihedral_angle_3d DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
        .p4_x(p4_x), .p4_y(p4_y), .p4_z(p4_z),
        .done(done), .angle(angle), .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    function automatic longint arctan_step(int i);
        longint acc;
        longint term;
        int     e;
        acc = 0;
        if (i == 0)
        begin
            return QUARTER_PI;
        end
        for (int n = 0; n < 64; n++)
        begin
            e = Q_FRAC - i * (2 * n + 1);
            if (e >= 0)
            begin
                term = longint'((64'd1 << e) / (2 * n + 1));
                acc = (n % 2 == 1) ? acc - term : acc + term;
            end
        end
        return acc;
    endfunction

    function automatic int bit_length(wide_t v);
        for (int b = 255; b >= 0; b--)
        begin
            if (v[b])
            begin
                return b + 1;
            end
        end
        return 0;
    endfunction

    function automatic torsion_t predict_torsion(quad_t q);
        wide_t    c [12];
        wide_t    v1 [3];
        wide_t    v2 [3];
        wide_t    v3 [3];
        wide_t    n1 [3];
        wide_t    n2 [3];
        wide_t    tv, xv, lv, rv, yv, ym, xm, trial;
        bit       yneg, xneg;
        int       m, mx;
        longint   ya, xa, z, tmp, dx, dy, a, lim;
        torsion_t res;
        for (int k = 0; k < 12; k++)
        begin
            c[k] = wide_t'(q.c[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            v1[i] = c[3 + i] - c[i];
            v2[i] = c[6 + i] - c[3 + i];
            v3[i] = c[9 + i] - c[6 + i];
        end
        n1[0] = v1[1] * v2[2] - v1[2] * v2[1];
        n1[1] = v1[2] * v2[0] - v1[0] * v2[2];
        n1[2] = v1[0] * v2[1] - v1[1] * v2[0];
        n2[0] = v2[1] * v3[2] - v2[2] * v3[1];
        n2[1] = v2[2] * v3[0] - v2[0] * v3[2];
        n2[2] = v2[0] * v3[1] - v2[1] * v3[0];
        tv = v1[0] * n2[0] + v1[1] * n2[1] + v1[2] * n2[2];
        xv = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
        lv = (v2[0] * v2[0] + v2[1] * v2[1] + v2[2] * v2[2]) <<< 64;
        rv = '0;
        for (int b = 80; b >= 0; b--)
        begin
            trial = rv | (wide_t'(1) << b);
            if (trial * trial <= lv)
            begin
                rv = trial;
            end
        end
        yv = rv * tv;
        xv = xv <<< 32;
        if (yv == 0 && xv == 0)
        begin
            res.angle = '0;
            res.degenerate = 1'b1;
            return res;
        end
        yneg = yv < 0;
        xneg = xv < 0;
        ym = yneg ? -yv : yv;
        xm = xneg ? -xv : xv;
        m = bit_length(ym);
        mx = bit_length(xm);
        if (mx > m)
        begin
            m = mx;
        end
        if (m > NORM_WIDTH)
        begin
            ym = ym >> (m - NORM_WIDTH);
            xm = xm >> (m - NORM_WIDTH);
        end
        else
        begin
            ym = ym << (NORM_WIDTH - m);
            xm = xm << (NORM_WIDTH - m);
        end
        ya = longint'(ym[31:0]);
        xa = longint'(xm[31:0]);
        if (yneg)
        begin
            ya = -ya;
        end
        if (xneg)
        begin
            xa = -xa;
        end
        z = 0;
        if (xa < 0)
        begin
            if (ya >= 0)
            begin
                tmp = ya;
                ya = -xa;
                xa = tmp;
                z = 2 * QUARTER_PI;
            end
            else
            begin
                tmp = -ya;
                ya = xa;
                xa = tmp;
                z = -2 * QUARTER_PI;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya >= 0)
            begin
                xa = xa + dx;
                ya = ya - dy;
                z = z + arctan_step(i);
            end
            else
            begin
                xa = xa - dx;
                ya = ya + dy;
                z = z - arctan_step(i);
            end
        end
        a = (z + (longint'(1) <<< (Q_FRAC - ANGLE_FRAC_BITS - 1))) >>> (Q_FRAC - ANGLE_FRAC_BITS);
        lim = (PI_Q61 + (longint'(1) <<< (Q_FRAC - ANGLE_FRAC_BITS - 1)))
              >>> (Q_FRAC - ANGLE_FRAC_BITS);
        if (a > lim)
        begin
            a = lim;
        end
        if (a < -lim)
        begin
            a = -lim;
        end
        res.angle = a[AW-1:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    task automatic send_request(quad_t q);
        start <= 1'b1;
        p1_x <= q.c[0];  p1_y <= q.c[1];  p1_z <= q.c[2];
        p2_x <= q.c[3];  p2_y <= q.c[4];  p2_z <= q.c[5];
        p3_x <= q.c[6];  p3_y <= q.c[7];  p3_z <= q.c[8];
        p4_x <= q.c[9];  p4_y <= q.c[10]; p4_z <= q.c[11];
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_torsions.push_back(predict_torsion(q));
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_torsions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] fixed(int v);
        return 32'(v) <<< 16;
    endfunction

    function automatic quad_t make_quad(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2, int d0, int d1, int d2);
        quad_t q;
        q.c[0] = a0; q.c[1] = a1; q.c[2] = a2;
        q.c[3] = b0; q.c[4] = b1; q.c[5] = b2;
        q.c[6] = c0; q.c[7] = c1; q.c[8] = c2;
        q.c[9] = d0; q.c[10] = d1; q.c[11] = d2;
        return q;
    endfunction

    function automatic logic signed [31:0] random_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2097152, 0)) - 1048576;
            2: return fixed($urandom_range(8, 0) - 4);
            default:
            begin
                case ($urandom_range(3, 0))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        int    mode;
        int    shape;
        mode = $urandom_range(3, 0);
        for (int k = 0; k < 12; k++)
        begin
            q.c[k] = random_coord(mode);
        end
        shape = $urandom_range(15, 0);
        if (shape == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q.c[6 + i] = q.c[3 + i];
            end
        end
        else if (shape == 1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q.c[3 + i] = q.c[i] + fixed(1);
                q.c[6 + i] = q.c[i] + fixed(2);
            end
        end
        else if (shape == 2)
        begin
            q.c[11] = q.c[2];
            q.c[9] = q.c[0];
            q.c[10] = q.c[1];
        end
        return q;
    endfunction

    task automatic test_directed();
        quad_t q;
        send_request(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_quad(0, 0, 0, fixed(1), 0, 0, fixed(2), 0, 0, fixed(3), 0, 0));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), fixed(1), 0));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), -fixed(1), 0));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), 0, fixed(1)));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), 0, -fixed(1)));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), fixed(1),
                               -1));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, fixed(1), 0, 0, fixed(1), fixed(1), 1));
        send_request(make_quad(0, fixed(1), 0, 0, 0, 0, 0, 0, 0, fixed(1), fixed(1), 0));
        pause_sender(3);
        for (int k = 0; k < 12; k++)
        begin
            q.c[k] = 32'sh7FFFFFFF;
        end
        send_request(q);
        for (int k = 0; k < 12; k++)
        begin
            q.c[k] = (k % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        send_request(q);
        for (int k = 0; k < 12; k++)
        begin
            q.c[k] = ((k / 3) % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        q.c[1] = 0;
        q.c[11] = 32'sh80000000;
        send_request(q);
        send_request(make_quad(32'sh80000000, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 0,
                               32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
        send_request(make_quad(1, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 1));
        send_request(make_quad(-1, -1, -1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                               0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 1));
        pause_sender(1);
    endtask

    task automatic test_random(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(40, 1);
                if ($urandom_range(3, 0) != 0)
                begin
                    pause_sender($urandom_range(12, 1));
                end
            end
            burst--;
            send_request(random_quad());
        end
    endtask

    task automatic test_drain_between_bursts();
        for (int r = 0; r < 3; r++)
        begin
            for (int n = 0; n < 10; n++)
            begin
                send_request(random_quad());
            end
            wait_for_results();
        end
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        torsion_t exp_t;
        if (rst_n && done)
        begin
            if (expected_torsions.size() == 0)
            begin
                $display("%0t: unexpected result angle=%0d degenerate=%0b",
                         $realtime, angle, degenerate);
                errors++;
            end
            else
            begin
                exp_t = expected_torsions.pop_front();
                if (angle !== exp_t.angle)
                begin
                    $display("%0t: angle expected %0d actual %0d",
                             $realtime, exp_t.angle, angle);
                    errors++;
                end
                if (degenerate !== exp_t.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $realtime, exp_t.degenerate, degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        start <= 1'b0;
        p1_x <= '0; p1_y <= '0; p1_z <= '0; p2_x <= '0; p2_y <= '0; p2_z <= '0;
        p3_x <= '0; p3_y <= '0; p3_z <= '0; p4_x <= '0; p4_y <= '0; p4_z <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_between_bursts();
        test_random(1400);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/dha_pkg.sv
hdl/dha_front.sv
hdl/dha_queue.sv
hdl/dha_sqrt.sv
hdl/dha_cordic.sv
hdl/dha_back.sv
hdl/dihedral_angle_3d.sv
bench/testbench.sv
